### rtl/core/scrg_pkg.sv
// Package with shared types, constants and a SHA-256 rotate helper function.
package scrg_pkg;

  localparam int unsigned DefMaxByteCount = 64;

  localparam logic [1:0] OP_SEED  = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;
  localparam logic [1:0] OP_BYTES = 2'd3;

  // Which message block the datapath loads before a compression.
  typedef enum logic [2:0] {
    BLK_CHAIN = 3'd0,  // V followed by padding for 32 bytes
    BLK_SEED  = 3'd1,  // zeros, seed, padding for 36 bytes
    BLK_ONES  = 3'd2,  // 0x01 bytes followed by key
    BLK_PAD64 = 3'd3   // padding-only block for a 64-byte message
  } blk_sel_t;

  // What the output register is loaded with.
  typedef enum logic [1:0] {
    OUT_WORD   = 2'd0,  // first word of V
    OUT_RANGED = 2'd1,  // remainder plus low bound
    OUT_LOW    = 2'd2,  // low bound unchanged
    OUT_BYTE   = 2'd3   // one byte of V
  } out_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;     // latch the accepted item
    logic      start;       // load a block and start a compression
    blk_sel_t  blk;
    logic      init_iv;     // start from the initial hash value
    logic      to_key;      // finished digest goes to the key register
    logic      to_chain;    // finished digest goes to V
    logic      mod_start;   // start the remainder unit
    logic      load_out;    // load the output register
    out_kind_t out_kind;
    logic [4:0] byte_pos;
  } scrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic mod_done;
  } scrg_sts_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] INIT_H =
    256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/core/scrg_datapath.sv
// Datapath: SHA-256 round engine, chain and key registers, remainder unit, output register.
module scrg_datapath
  import scrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  scrg_cmd_t   cmd,
  output scrg_sts_t   sts,
  input  logic [31:0] in_seed_value,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  output logic [31:0] out_value
);

  logic [255:0] chain_r;
  logic [255:0] key_r;
  logic [255:0] hbase_r;
  logic [31:0]  seed_r, low_r, high_r;
  logic [31:0]  w_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]   rnd_r;
  logic         busy_r, hdone_r;
  logic [31:0]  mod_rem_r, mod_div_r, mod_src_r;
  logic [5:0]   mod_cnt_r;
  logic         mod_busy_r, mdone_r;
  logic [31:0]  val_r;

  // Message block chosen by the controller.
  logic [511:0] blk;
  always_comb begin
    case (cmd.blk)
      BLK_CHAIN: blk = {chain_r, 8'h80, 184'd0, 64'd256};
      BLK_SEED:  blk = {256'd0, seed_r[7:0], seed_r[15:8], seed_r[23:16], seed_r[31:24],
                        8'h80, 152'd0, 64'd288};
      BLK_ONES:  blk = {{32{8'h01}}, key_r};
      BLK_PAD64: blk = {8'h80, 440'd0, 64'd512};
      default:   blk = '0;
    endcase
  end

  // One compression round per cycle.
  logic [31:0] t1, t2, s0, s1, wnew;
  always_comb begin
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) + ((e_r & f_r) ^ (~e_r & g_r))
         + ROUND_K[rnd_r] + w_r[0];
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) ^ 32'd0;
    t2 = t2 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
  end

  logic [255:0] digest;
  assign digest = {hbase_r[255:224] + a_r, hbase_r[223:192] + b_r, hbase_r[191:160] + c_r,
                   hbase_r[159:128] + d_r, hbase_r[127:96] + e_r, hbase_r[95:64] + f_r,
                   hbase_r[63:32] + g_r, hbase_r[31:0] + h_r};

  logic [255:0] hstart;
  assign hstart = cmd.init_iv ? INIT_H : hbase_r;

  // Hash engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      hdone_r <= 1'b0;
      chain_r <= '0;
      rnd_r   <= '0;
    end else begin
      hdone_r <= 1'b0;
      if (cmd.start) begin
        busy_r  <= 1'b1;
        rnd_r   <= '0;
        hbase_r <= hstart;
        {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= hstart;
        for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
      end else if (busy_r) begin
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r  <= 1'b0;
          hdone_r <= 1'b1;
        end
      end
      if (hdone_r) begin
        hbase_r <= digest;
        if (cmd.to_key)   key_r   <= digest;
        if (cmd.to_chain) chain_r <= digest;
      end
    end
  end

  // Restoring remainder, one quotient bit per cycle.
  logic [32:0] trial;
  assign trial = {mod_rem_r, mod_src_r[31]} - {1'b0, mod_div_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mdone_r    <= 1'b0;
      mod_cnt_r  <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mod_start) begin
        mod_busy_r <= 1'b1;
        mod_cnt_r  <= '0;
        mod_rem_r  <= '0;
        mod_src_r  <= chain_r[255:224];
        mod_div_r  <= high_r - low_r;
      end else if (mod_busy_r) begin
        if (!trial[32]) mod_rem_r <= trial[31:0];
        else            mod_rem_r <= {mod_rem_r[30:0], mod_src_r[31]};
        mod_src_r <= {mod_src_r[30:0], 1'b0};
        mod_cnt_r <= mod_cnt_r + 6'd1;
        if (mod_cnt_r == 6'd31) begin
          mod_busy_r <= 1'b0;
          mdone_r    <= 1'b1;
        end
      end
    end
  end

  // Item capture and output value.
  logic [31:0] byte_word;
  assign byte_word = chain_r[255 - 32*cmd.byte_pos[4:2] -: 32];
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed_r <= in_seed_value;
      low_r  <= in_range_low;
      high_r <= in_range_high;
    end
    if (cmd.load_out) begin
      case (cmd.out_kind)
        OUT_WORD:   val_r <= chain_r[255:224];
        OUT_RANGED: val_r <= mod_rem_r + low_r;
        OUT_LOW:    val_r <= low_r;
        default:    val_r <= {24'd0, byte_word[31 - 8*cmd.byte_pos[1:0] -: 8]};
      endcase
    end
  end

  assign out_value     = val_r;
  assign sts.hash_done = hdone_r;
  assign sts.mod_done  = mdone_r;

endmodule

### rtl/core/scrg_ctrl.sv
// Controller state machine that sequences compressions, the remainder and result items.
module scrg_ctrl
  import scrg_pkg::*;
#(
  parameter int unsigned MAX_BYTE_COUNT = DefMaxByteCount
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [6:0] in_byte_count,
  input  logic       in_low_ge_high,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_last,
  output scrg_cmd_t  cmd,
  input  scrg_sts_t  sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_HASH  = 8'b00000010,
    S_MOD   = 8'b00000100,
    S_EMIT  = 8'b00001000,
    S_WAIT  = 8'b00010000,
    S_START = 8'b00100000,
    S_NEXT  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  localparam logic [6:0] MaxCnt = 7'(MAX_BYTE_COUNT);

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] step_r, step_nxt;  // compression index within a seed
  logic [6:0] cnt_r, cnt_nxt;    // bytes still to give
  logic [5:0] idx_r, idx_nxt;    // byte index in the run
  logic       ov_r, ov_nxt;
  logic       last_r, last_nxt;
  logic       lowonly_r, lowonly_nxt;  // ranged item returns its low bound

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    ov_nxt      = ov_r;
    last_nxt    = last_r;
    lowonly_nxt = lowonly_r;
    cmd       = '0;
    cmd.blk   = BLK_CHAIN;
    cmd.byte_pos = idx_r[4:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt   = in_op;
          step_nxt = '0;
          idx_nxt  = '0;
          cnt_nxt  = (in_byte_count > MaxCnt) ? MaxCnt : in_byte_count;
          lowonly_nxt = (in_op == OP_RANGE) && in_low_ge_high;
          if (in_op == OP_RANGE && in_low_ge_high) begin
            state_nxt = S_WAIT;
          end else if (in_op == OP_BYTES && in_byte_count == 7'd0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        cmd.start   = 1'b1;
        cmd.init_iv = (step_r != 2'd2);
        case (step_r)
          2'd0:    cmd.blk = (op_r == OP_SEED) ? BLK_SEED : BLK_CHAIN;
          2'd1:    cmd.blk = BLK_ONES;
          default: cmd.blk = BLK_PAD64;
        endcase
        state_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.to_key   = (op_r == OP_SEED) && (step_r == 2'd0);
        cmd.to_chain = (op_r != OP_SEED) || (step_r == 2'd2);
        if (sts.hash_done) begin
          if (op_r == OP_SEED) begin
            if (step_r == 2'd2) state_nxt = S_IDLE;
            else begin
              step_nxt  = step_r + 2'd1;
              state_nxt = S_START;
            end
          end else if (op_r == OP_RANGE) state_nxt = S_NEXT;
          else state_nxt = S_WAIT;
        end
      end
      S_NEXT: begin
        cmd.mod_start = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        // Output register free: load the next result.
        if (!ov_nxt) begin
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1;
          case (op_r)
            OP_WORD:  begin cmd.out_kind = OUT_WORD; last_nxt = 1'b1; end
            OP_RANGE: begin
              cmd.out_kind = lowonly_r ? OUT_LOW : OUT_RANGED;
              last_nxt = 1'b1;
            end
            default:  begin cmd.out_kind = OUT_BYTE; last_nxt = (cnt_r == 7'd1); end
          endcase
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (op_r == OP_BYTES && cnt_r != 7'd1) begin
          cnt_nxt = cnt_r - 7'd1;
          idx_nxt = idx_r + 6'd1;
          state_nxt = (idx_nxt[4:0] == 5'd0) ? S_START : S_WAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_nxt) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_SEED;
      step_r    <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      ov_r      <= 1'b0;
      last_r    <= 1'b0;
      lowonly_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      step_r    <= step_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      ov_r      <= ov_nxt;
      last_r    <= last_nxt;
      lowonly_r <= lowonly_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_last  = last_r;

endmodule

### rtl/core/sha256_chain_random_generator_unit.sv
// A word takes one compression; a ranged word takes one compression and the remainder;
// a ranged word with low >= high takes neither, and a seed runs three compressions.
// A byte run does one compression per 32 bytes.
// One item is in work at a time; the next is taken once the controller is back in idle.
// The round engine runs one SHA-256 round per cycle and the remainder unit one bit per cycle.
// Synchronous active-low reset clears V to zero and empties the output register.
module sha256_chain_random_generator_unit
  import scrg_pkg::*;
#(
  parameter int unsigned MAX_BYTE_COUNT = DefMaxByteCount
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_seed_value,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  input  logic [6:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_last
);

  scrg_cmd_t cmd;
  scrg_sts_t sts;

  scrg_ctrl #(.MAX_BYTE_COUNT(MAX_BYTE_COUNT)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_byte_count,
    .in_low_ge_high(in_range_low >= in_range_high),
    .out_valid, .out_stall, .out_last, .cmd, .sts
  );

  scrg_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_seed_value, .in_range_low, .in_range_high,
    .out_value
  );

endmodule

### rtl/core/scrg_checker.sv
// Port-level checker for the generator and its bind statement.
module scrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value,
  input logic        out_last
);

  // A waiting result keeps its value and flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // Input is never taken while a result is still due from the item in work.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall || !out_valid)
    else $error("item accepted during output");

  // Results come only while the block is busy with an item.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while idle");

endmodule

bind sha256_chain_random_generator_unit scrg_checker u_scrg_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_value, .out_last
);
